>>> hw/rtl/arfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfb_pkg
// Shared types and constants for the translucent rectangle fill blender.
// ----------------------------------------------------------------------------
package arfb_pkg;

	localparam int COORD_W   = 16;
	localparam int COLOR_W   = 8;
	localparam int ALPHA_W   = 9;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_RED    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_GREEN  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_BLUE   = 4'd7;

	// Fully opaque alpha
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

	typedef struct packed {
		logic [COORD_W-1:0] rect_left;
		logic [COORD_W-1:0] rect_top;
		logic [COORD_W-1:0] rect_width;
		logic [COORD_W-1:0] rect_height;
		logic [ALPHA_W-1:0] blend_alpha;
		logic [COLOR_W-1:0] fill_red;
		logic [COLOR_W-1:0] fill_green;
		logic [COLOR_W-1:0] fill_blue;
	} arfb_cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} arfb_pos_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} arfb_color_t;

	typedef struct packed {
		logic [COLOR_W-1:0] bg_red;
		logic [COLOR_W-1:0] bg_green;
		logic [COLOR_W-1:0] bg_blue;
	} arfb_bg_t;

	typedef struct packed {
		logic [COORD_W-1:0] pix_x;
		logic [COORD_W-1:0] pix_y;
		logic [COLOR_W-1:0] out_red;
		logic [COLOR_W-1:0] out_green;
		logic [COLOR_W-1:0] out_blue;
		logic               last_pixel;
	} arfb_pix_t;

endpackage

>>> hw/rtl/arfb_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfb_stream_if
// Valid/ready stream channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface arfb_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/arfb_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfb_cfg
// Configuration register file; flags geometry writes to restart the scan.
// ----------------------------------------------------------------------------
module arfb_cfg
	import arfb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output arfb_cfg_t             cfg,
	output logic                  restart
);

	arfb_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rect_left   <= '0;
			cfg_q.rect_top    <= '0;
			cfg_q.rect_width  <= COORD_W'(1);
			cfg_q.rect_height <= COORD_W'(1);
			cfg_q.blend_alpha <= ALPHA_ONE;
			cfg_q.fill_red    <= '0;
			cfg_q.fill_green  <= '0;
			cfg_q.fill_blue   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_RECT_LEFT:   cfg_q.rect_left   <= cfg_wdata[COORD_W-1:0];
				REG_RECT_TOP:    cfg_q.rect_top    <= cfg_wdata[COORD_W-1:0];
				REG_RECT_WIDTH:  cfg_q.rect_width  <= cfg_wdata[COORD_W-1:0];
				REG_RECT_HEIGHT: cfg_q.rect_height <= cfg_wdata[COORD_W-1:0];
				REG_BLEND_ALPHA: cfg_q.blend_alpha <= cfg_wdata[ALPHA_W-1:0];
				REG_FILL_RED:    cfg_q.fill_red    <= cfg_wdata[COLOR_W-1:0];
				REG_FILL_GREEN:  cfg_q.fill_green  <= cfg_wdata[COLOR_W-1:0];
				REG_FILL_BLUE:   cfg_q.fill_blue   <= cfg_wdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Geometry change sends the scan back to the origin
	always_comb begin
		restart = 1'b0;
		if (cfg_wr_en) begin
			case (cfg_index) inside
				REG_RECT_LEFT, REG_RECT_TOP, REG_RECT_WIDTH, REG_RECT_HEIGHT:
					restart = 1'b1;
				default:
					restart = 1'b0;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/arfb_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfb_scan
// Column-major position counters for the rectangle scan.
// ----------------------------------------------------------------------------
module arfb_scan
	import arfb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  arfb_cfg_t cfg,
	input  logic      restart,
	input  logic      step,
	output arfb_pos_t pos
);

	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W:0]   col_inc;
	logic [COORD_W:0]   row_inc;
	logic               last_col;
	logic               last_row;

	assign col_inc  = {1'b0, col_q} + (COORD_W+1)'(1);
	assign row_inc  = {1'b0, row_q} + (COORD_W+1)'(1);
	assign last_col = col_inc >= {1'b0, cfg.rect_width};
	assign last_row = row_inc >= {1'b0, cfg.rect_height};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (last_row) begin
				row_q <= '0;
				col_q <= last_col ? '0 : col_inc[COORD_W-1:0];
			end else begin
				row_q <= row_inc[COORD_W-1:0];
			end
		end
	end

	assign pos.x    = cfg.rect_left + col_q;
	assign pos.y    = cfg.rect_top + row_q;
	assign pos.last = last_row & last_col;

endmodule

>>> hw/rtl/arfb_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfb_mix
// Per-channel alpha blend of the fill color over a background pixel.
// ----------------------------------------------------------------------------
module arfb_mix
	import arfb_pkg::*;
(
	input  arfb_cfg_t   cfg,
	input  arfb_bg_t    bg,
	output arfb_color_t color
);

	logic [ALPHA_W-1:0] alpha;
	logic [ALPHA_W-1:0] alpha_inv;

	function automatic logic [COLOR_W-1:0] mix_channel(
		input logic [ALPHA_W-1:0] a,
		input logic [ALPHA_W-1:0] a_inv,
		input logic [COLOR_W-1:0] fg,
		input logic [COLOR_W-1:0] bk
	);
		logic [ALPHA_W+COLOR_W-1:0] sum;
		sum = a * fg + a_inv * bk;
		return sum[ALPHA_W+COLOR_W-2 -: COLOR_W];
	endfunction

	// Saturate anything above opaque
	assign alpha     = (cfg.blend_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.blend_alpha;
	assign alpha_inv = ALPHA_ONE - alpha;

	assign color.red   = mix_channel(alpha, alpha_inv, cfg.fill_red, bg.bg_red);
	assign color.green = mix_channel(alpha, alpha_inv, cfg.fill_green, bg.bg_green);
	assign color.blue  = mix_channel(alpha, alpha_inv, cfg.fill_blue, bg.bg_blue);

endmodule

>>> hw/rtl/alpha_rect_fill_blender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_rect_fill_blender
// Translucent rectangle fill over a streamed background picture.
// ----------------------------------------------------------------------------
// Usage:
//   bg  (sink)   : one background pixel per item, in column-major order of
//                  the rectangle (x outer, y inner).
//   pix (source) : one blended pixel per item with its x/y position and a
//                  last_pixel flag on the final pixel of the rectangle.
//   cfg port     : cfg_wr_en/cfg_index/cfg_wdata write the registers; write
//                  only while no item is in flight. Geometry writes restart
//                  the scan at the origin.
// An item taken on bg is registered in the input stage, which holds the pixel
// and its position, and then in the result stage, which holds the blended
// color and drives pix.valid.
// One item per clock while pix.ready holds: both stages advance together, so
// bg stays ready while the result stage drains into a ready receiver.
// With width or height zero, items are consumed and produce nothing.
// Reset clears the valid flags and scan counters and loads the register
// defaults (1x1 rectangle at the origin, opaque black).
// A stalled receiver holds the result stage; the input stage fills and then
// bg.ready drops until pix.ready returns.
// ----------------------------------------------------------------------------
module alpha_rect_fill_blender
	import arfb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	arfb_stream_if.sink           bg,
	arfb_stream_if.source         pix,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	arfb_cfg_t   cfg;
	logic        restart;
	arfb_pos_t   pos;
	arfb_color_t color;

	logic        bg_accept;
	logic        rect_empty;
	logic        adv_s2;
	logic        adv_s1;

	logic        valid_s1;
	arfb_bg_t    bg_s1;
	arfb_pos_t   pos_s1;

	logic        valid_s2;
	arfb_pix_t   pix_s2;

	arfb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.restart   (restart)
	);

	// Empty rectangle: accept the item, drop it, leave the scan alone
	assign rect_empty = (cfg.rect_width == '0) || (cfg.rect_height == '0);

	// Result stage frees up when empty or being taken this cycle
	assign adv_s2    = !valid_s2 || pix.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign bg.ready  = adv_s1;
	assign bg_accept = bg.valid && bg.ready;

	arfb_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (restart),
		.step    (bg_accept && !rect_empty),
		.pos     (pos)
	);

	// Input stage: capture the background pixel with its position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= bg_accept && !rect_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (bg_accept) begin
			bg_s1  <= bg.payload;
			pos_s1 <= pos;
		end
	end

	arfb_mix u_mix (
		.cfg   (cfg),
		.bg    (bg_s1),
		.color (color)
	);

	// Result stage: hold the blended pixel until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pix_s2.pix_x      <= pos_s1.x;
			pix_s2.pix_y      <= pos_s1.y;
			pix_s2.out_red    <= color.red;
			pix_s2.out_green  <= color.green;
			pix_s2.out_blue   <= color.blue;
			pix_s2.last_pixel <= pos_s1.last;
		end
	end

	assign pix.valid   = valid_s2;
	assign pix.payload = pix_s2;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for alpha_rect_fill_blender. Background pixels go in on
// the bg channel and blended pixels come back on pix. A built-in predictor
// keeps its own copy of the registers and the scan position and works out
// every expected pixel. A short table of directed rows comes first, then
// phases of random geometry, alpha, color and background content. Both
// channel ends idle at random, the receiver holds off once for a long
// stretch, and the sender once waits for the pipeline to empty.
// ----------------------------------------------------------------------------
module tb
	import arfb_pkg::*;
();

	localparam int CLK_HIGH        = 6;
	localparam int CLK_LOW         = 6;
	localparam int RESET_CYCLES    = 4;
	localparam int RANDOM_ITEMS    = 1100;
	localparam int PIPE_SETTLE     = 4;      // two-stage pipeline plus margin
	localparam int IDLE_MAX        = 19;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int HOLD_PHASE      = 2;
	localparam int PAUSE_PHASE     = 4;

	// First index past the register file; writes from here up are ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = REG_FILL_BLUE + 4'd1;

	// Directed stimulus: a register write, a pixel checked by the predictor,
	// or a pixel whose result is typed in the table
	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_PIXEL,
		ROW_PIXEL_KNOWN
	} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] wdata;
		arfb_bg_t              bg;
		arfb_pix_t             known;
	} dir_row_t;

	typedef struct packed {
		logic      typed;
		arfb_pix_t pix;
	} known_pix_t;

	localparam arfb_pix_t NO_PIX = '0;
	localparam arfb_bg_t  NO_BG  = '0;

	// Known results read {x, y} as 32 zero bits, then the color, then last_pixel.
	localparam int DIR_ROWS_N = 29;
	localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
		// after reset: 1x1 at the origin, opaque black
		'{ROW_PIXEL_KNOWN, '0, 16'h0000, 24'hFFFFFF, {32'h0, 24'h000000, 1'b1}},
		'{ROW_PIXEL_KNOWN, '0, 16'h0000, 24'h000000, {32'h0, 24'h000000, 1'b1}},
		// fully transparent: background passes through
		'{ROW_WRITE, REG_BLEND_ALPHA, 16'h0000, NO_BG, NO_PIX},
		'{ROW_WRITE, REG_FILL_RED,    16'h00FF, NO_BG, NO_PIX},
		'{ROW_WRITE, REG_FILL_GREEN,  16'h0080, NO_BG, NO_PIX},
		'{ROW_WRITE, REG_FILL_BLUE,   16'h0001, NO_BG, NO_PIX},
		'{ROW_PIXEL_KNOWN, '0, 16'h0000, 24'h123456, {32'h0, 24'h123456, 1'b1}},
		// exactly opaque, then alpha above opaque saturates
		'{ROW_WRITE, REG_BLEND_ALPHA, 16'h0100, NO_BG, NO_PIX},
		'{ROW_PIXEL_KNOWN, '0, 16'h0000, 24'h000000, {32'h0, 24'hFF8001, 1'b1}},
		'{ROW_WRITE, REG_BLEND_ALPHA, 16'h01FF, NO_BG, NO_PIX},
		'{ROW_PIXEL_KNOWN, '0, 16'h0000, 24'hA5A5A5, {32'h0, 24'hFF8001, 1'b1}},
		// bits above the alpha field drop, leaving zero
		'{ROW_WRITE, REG_BLEND_ALPHA, 16'hFE00, NO_BG, NO_PIX},
		'{ROW_PIXEL_KNOWN, '0, 16'h0000, 24'h00FF7F, {32'h0, 24'h00FF7F, 1'b1}},
		// half blend
		'{ROW_WRITE, REG_BLEND_ALPHA, 16'h0080, NO_BG, NO_PIX},
		'{ROW_PIXEL, '0, 16'h0000, 24'h00FF80, NO_PIX},
		// empty rectangle, zero width then zero height
		'{ROW_WRITE, REG_RECT_WIDTH,  16'h0000, NO_BG, NO_PIX},
		'{ROW_PIXEL, '0, 16'h0000, 24'h111111, NO_PIX},
		'{ROW_WRITE, REG_RECT_WIDTH,  16'h0002, NO_BG, NO_PIX},
		'{ROW_WRITE, REG_RECT_HEIGHT, 16'h0000, NO_BG, NO_PIX},
		'{ROW_PIXEL, '0, 16'h0000, 24'h222222, NO_PIX},
		// 2x2 at the top corner: both coordinates wrap
		'{ROW_WRITE, REG_RECT_HEIGHT, 16'h0002, NO_BG, NO_PIX},
		'{ROW_WRITE, REG_RECT_LEFT,   16'hFFFF, NO_BG, NO_PIX},
		'{ROW_WRITE, REG_RECT_TOP,    16'hFFFF, NO_BG, NO_PIX},
		'{ROW_PIXEL, '0, 16'h0000, 24'hFF00FF, NO_PIX},
		// color write and unmapped write mid-scan must not restart it
		'{ROW_WRITE, REG_FILL_GREEN,  16'h0000, NO_BG, NO_PIX},
		'{ROW_WRITE, REG_UNMAPPED_LO, 16'hFFFF, NO_BG, NO_PIX},
		'{ROW_PIXEL, '0, 16'h0000, 24'h7F8081, NO_PIX},
		'{ROW_PIXEL, '0, 16'h0000, 24'hFFFFFF, NO_PIX},
		'{ROW_PIXEL, '0, 16'h0000, 24'h000000, NO_PIX}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	arfb_stream_if #(.payload_t(arfb_bg_t))  bg_if ();
	arfb_stream_if #(.payload_t(arfb_pix_t)) pix_if ();

	alpha_rect_fill_blender i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bg        (bg_if),
		.pix       (pix_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor state: register copy and scan position inside the rectangle
	arfb_cfg_t    fill_cfg;
	logic [15:0]  scan_col;
	logic [15:0]  scan_row;

	arfb_pix_t    pending_pix[$];   // blended pixels still to come out
	known_pix_t   known_q[$];       // typed results of directed pixels, in send order

	int           mismatches  = 0;
	int           cycle_count = 0;
	int           gap_max     = 3;
	int           stall_max   = 3;
	bit           hold_req    = 1'b0;

	always begin
		#CLK_HIGH clk = 1'b1;
		#CLK_LOW  clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic logic [COLOR_W-1:0] mix_channel(logic [ALPHA_W-1:0] a,
			logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bgc);
		int unsigned sum;
		sum = int'(a) * int'(fg) + (int'(ALPHA_ONE) - int'(a)) * int'(bgc);
		return sum[15:8];
	endfunction

	// Mirror a register write; geometry writes send the scan back to the origin.
	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_RECT_LEFT: begin
				fill_cfg.rect_left = d; scan_col = '0; scan_row = '0;
			end
			REG_RECT_TOP: begin
				fill_cfg.rect_top = d; scan_col = '0; scan_row = '0;
			end
			REG_RECT_WIDTH: begin
				fill_cfg.rect_width = d; scan_col = '0; scan_row = '0;
			end
			REG_RECT_HEIGHT: begin
				fill_cfg.rect_height = d; scan_col = '0; scan_row = '0;
			end
			REG_BLEND_ALPHA: fill_cfg.blend_alpha = d[ALPHA_W-1:0];
			REG_FILL_RED:    fill_cfg.fill_red    = d[COLOR_W-1:0];
			REG_FILL_GREEN:  fill_cfg.fill_green  = d[COLOR_W-1:0];
			REG_FILL_BLUE:   fill_cfg.fill_blue   = d[COLOR_W-1:0];
			default: ;
		endcase
	endfunction

	// Blend one background pixel at the current scan position and advance the
	// scan, rows inner. Returns 0 when the rectangle is empty.
	function automatic bit blend_next_pixel(arfb_bg_t px, output arfb_pix_t res);
		logic [ALPHA_W-1:0] a;
		bit                 end_row;
		bit                 end_col;
		res = '0;
		if (fill_cfg.rect_width == '0 || fill_cfg.rect_height == '0)
			return 1'b0;
		a = (fill_cfg.blend_alpha > ALPHA_ONE) ? ALPHA_ONE : fill_cfg.blend_alpha;
		end_row = (17'(scan_row) + 17'd1 >= 17'(fill_cfg.rect_height));
		end_col = (17'(scan_col) + 17'd1 >= 17'(fill_cfg.rect_width));
		res.pix_x      = fill_cfg.rect_left + scan_col;
		res.pix_y      = fill_cfg.rect_top + scan_row;
		res.out_red    = mix_channel(a, fill_cfg.fill_red, px.bg_red);
		res.out_green  = mix_channel(a, fill_cfg.fill_green, px.bg_green);
		res.out_blue   = mix_channel(a, fill_cfg.fill_blue, px.bg_blue);
		res.last_pixel = end_row && end_col;
		if (end_row) begin
			scan_row = '0;
			scan_col = end_col ? '0 : scan_col + 16'd1;
		end else begin
			scan_row = scan_row + 16'd1;
		end
		return 1'b1;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Monitor: everything is sampled at the clock edge, in one process, so
	// register writes, predictions and checks keep their order within a step.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		arfb_pix_t  predicted;
		arfb_pix_t  want;
		arfb_pix_t  got;
		known_pix_t known;
		bit         produced;
		if (arst_n) begin
			if (cfg_wr_en)
				apply_reg(cfg_index, cfg_wdata);
			if (bg_if.valid && bg_if.ready) begin
				produced = blend_next_pixel(bg_if.payload, predicted);
				// directed pixels with a typed result take it over the prediction
				if (known_q.size() != 0) begin
					known = known_q.pop_front();
					if (known.typed)
						predicted = known.pix;
				end
				if (produced)
					pending_pix.push_back(predicted);
			end
			if (pix_if.valid && pix_if.ready) begin
				got = pix_if.payload;
				if (pending_pix.size() == 0) begin
					$error("pixel at x %0h y %0h with none pending", got.pix_x, got.pix_y);
					mismatches++;
				end else begin
					want = pending_pix.pop_front();
					check_field("pix_x",      want.pix_x,      got.pix_x);
					check_field("pix_y",      want.pix_y,      got.pix_y);
					check_field("out_red",    want.out_red,    got.out_red);
					check_field("out_green",  want.out_green,  got.out_green);
					check_field("out_blue",   want.out_blue,   got.out_blue);
					check_field("last_pixel", want.last_pixel, got.last_pixel);
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: stall a random number of cycles before each item, and hold off
	// for a long stretch when asked so the pipeline backs up into bg.
	// ------------------------------------------------------------------------
	initial begin : receiver
		int stall;
		pix_if.ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				pix_if.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = (stall_max != 0) ? $urandom_range(0, stall_max) : 0;
			if (stall != 0) begin
				pix_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pix_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(pix_if.valid && pix_if.ready));
		end
	end

	// ------------------------------------------------------------------------
	// Sender and register tasks
	// ------------------------------------------------------------------------
	// Offer one background pixel after a random gap and hold it until taken.
	task automatic offer_bg(arfb_bg_t px);
		int gap;
		gap = (gap_max != 0) ? $urandom_range(0, gap_max) : 0;
		if (gap != 0) begin
			bg_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bg_if.valid   <= 1'b1;
		bg_if.payload <= px;
		do
			@(posedge clk);
		while (!(bg_if.valid && bg_if.ready));
	endtask

	// Drop valid, wait for every pending pixel, then let the pipeline empty out
	// in case the last items fell into an empty rectangle.
	task automatic settle();
		bg_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_pix.size() != 0);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_coord();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return 16'hFFFF;
			2:       return 16'hFFFF - 16'($urandom_range(0, 7));
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly small rectangles so the scan wraps often; a few empty or huge ones.
	function automatic logic [CFG_DATA_W-1:0] pick_extent();
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(7, 65535));
			default: return 16'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_alpha();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return 16'(ALPHA_ONE);
			2:       return 16'($urandom_range(0, 256));
			3:       return 16'($urandom_range(257, 511));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_idle();
		return ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int       filled;
		int       phase;
		int       n_items;
		bit       has_area;
		arfb_bg_t px;

		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		bg_if.valid    = 1'b0;
		bg_if.payload  = '0;

		// predictor starts from the register defaults
		fill_cfg             = '0;
		fill_cfg.rect_width  = 16'd1;
		fill_cfg.rect_height = 16'd1;
		fill_cfg.blend_alpha = ALPHA_ONE;
		scan_col             = '0;
		scan_row             = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; settle before every write so the block is idle
		for (int i = 0; i < DIR_ROWS_N; i++) begin
			if (DIR_ROWS[i].kind == ROW_WRITE) begin
				settle();
				write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].wdata);
			end else begin
				known_q.push_back('{DIR_ROWS[i].kind == ROW_PIXEL_KNOWN, DIR_ROWS[i].known});
				offer_bg(DIR_ROWS[i].bg);
			end
		end

		// Random phases: new geometry and colors, then a burst of background pixels
		filled = 0;
		phase  = 0;
		while (filled < RANDOM_ITEMS) begin
			settle();
			gap_max   = pick_idle();
			stall_max = pick_idle();

			// sometimes keep the geometry so the scan carries on mid-rectangle
			if (phase == 0 || $urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 3) != 0)
					write_reg(REG_RECT_LEFT, pick_coord());
				if ($urandom_range(0, 3) != 0)
					write_reg(REG_RECT_TOP, pick_coord());
				write_reg(REG_RECT_WIDTH, pick_extent());
				write_reg(REG_RECT_HEIGHT, pick_extent());
			end
			if (phase == HOLD_PHASE || phase == PAUSE_PHASE) begin
				write_reg(REG_RECT_WIDTH, 16'($urandom_range(1, 6)));
				write_reg(REG_RECT_HEIGHT, 16'($urandom_range(1, 6)));
			end
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_BLEND_ALPHA, pick_alpha());
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_FILL_RED, 16'($urandom));
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_FILL_GREEN, 16'($urandom));
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_FILL_BLUE, 16'($urandom));
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_UNMAPPED_LO + 4'($urandom_range(0, 7)), 16'($urandom));

			// the monitor has mirrored the writes by now
			has_area = (fill_cfg.rect_width != '0) && (fill_cfg.rect_height != '0);
			n_items  = has_area ? $urandom_range(10, 60) : $urandom_range(3, 10);

			// back-to-back items into a receiver that holds off
			if (phase == HOLD_PHASE) begin
				gap_max  = 0;
				n_items  = 60;
				hold_req = 1'b1;
			end

			for (int k = 0; k < n_items; k++) begin
				// pause the sender until every pending pixel is out
				if (phase == PAUSE_PHASE && k == n_items / 2) begin
					bg_if.valid <= 1'b0;
					do
						@(posedge clk);
					while (pending_pix.size() != 0);
				end
				px = arfb_bg_t'(24'($urandom));
				offer_bg(px);
			end
			if (has_area)
				filled += n_items;
			phase++;
		end

		settle();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
